>>> rtl/core/fpc_pkg.sv
// shared constants, types and the crc byte update for the frame parser
`default_nettype none

package fpc_pkg;

	// largest payload length accepted before a length error is raised
	localparam int unsigned MAX_PAYLOAD = 128;

	localparam int unsigned RX_W    = 8;
	localparam int unsigned IDX_W   = 7;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned CRC_W   = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// payload counter must hold MAX_PAYLOAD and feed the 7-bit index
	localparam int unsigned CNT_RAW_W = $clog2(MAX_PAYLOAD + 1);
	localparam int unsigned CNT_W     = (CNT_RAW_W > IDX_W) ? CNT_RAW_W : IDX_W;

	localparam logic [CRC_W-1:0] CRC_POLY_REFL = 16'hA001;
	localparam logic [CRC_W-1:0] CRC_INIT      = 16'h0000;

	localparam logic [RX_W-1:0] HDR_FIRST_RST  = 8'hAA;
	localparam logic [RX_W-1:0] HDR_SECOND_RST = 8'h44;
	localparam logic [RX_W-1:0] HDR_THIRD_RST  = 8'h16;

	typedef enum logic [2:0] {
		PH_HEAD0,
		PH_HEAD1,
		PH_HEAD2,
		PH_LENLO,
		PH_LENHI,
		PH_DATA,
		PH_CRCLO,
		PH_CRCHI
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE,
		EV_PAYLOAD,
		EV_GOOD,
		EV_CRCERR,
		EV_LENERR
	} ev_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HDR_FIRST,
		REG_HDR_SECOND,
		REG_HDR_THIRD
	} reg_idx_t;

	// crc-16/arc, reflected, one byte per call, eight shift steps
	function automatic logic [CRC_W-1:0] crc_arc_byte(
		input logic [CRC_W-1:0] crc_in,
		input logic [RX_W-1:0]  data_in
	);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {{(CRC_W-RX_W){1'b0}}, data_in};
		for (int k = 0; k < RX_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY_REFL;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/fpc_if.sv
// channel interfaces of the frame parser: received bytes, results, register writes
`default_nettype none

interface fpc_rx_if;
	import fpc_pkg::*;
	logic            valid;
	logic            ready;
	logic [RX_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpc_ev_if;
	import fpc_pkg::*;
	logic             valid;
	logic             ready;
	ev_t              event_code;
	logic [RX_W-1:0]  payload_byte;
	logic [IDX_W-1:0] payload_index;
	logic [LEN_W-1:0] frame_length;
	logic [CRC_W-1:0] crc_value;

	modport source (output valid, output event_code, output payload_byte,
		output payload_index, output frame_length, output crc_value, input ready);
	modport sink   (input valid, input event_code, input payload_byte,
		input payload_index, input frame_length, input crc_value, output ready);
endinterface

interface fpc_cfg_if;
	import fpc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [RX_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/frame_parser_crc16.sv
// frame parser top level: header hunt, length, payload and crc-16/arc check
//
// channel  | dir | payload                                   | item
// ---------+-----+-------------------------------------------+---------------------------
// rx_ch    | in  | rx_byte                                   | one received byte
// ev_ch    | out | event_code, payload_byte, payload_index,  | one result per byte
//          |     | frame_length, crc_value                   |
// cfg_ch   | in  | index, data                               | one header byte write
//
// one item per cycle while ev_ch is not stalled; each byte passes the phase decode and crc update combinationally
// a result appears on ev_ch the cycle after its byte is taken, from the result register
// rx_ch is ready whenever the result register is empty or being emptied in the same cycle
// a stall on ev_ch holds the result and stops intake; parser state moves only on intake
// arst_n clears the phase, the result valid flag and restores the default header bytes
// cfg_ch is always ready; writes to an unknown index are dropped
`default_nettype none

module frame_parser_crc16 (
	input  wire logic clk,
	input  wire logic arst_n,
	fpc_rx_if.sink    rx_ch,
	fpc_ev_if.source  ev_ch,
	fpc_cfg_if.sink   cfg_ch
);
	import fpc_pkg::*;

	// header bytes, written through the register port
	logic [RX_W-1:0] hdr_first_q;
	logic [RX_W-1:0] hdr_second_q;
	logic [RX_W-1:0] hdr_third_q;

	// parser state
	phase_t           phase_q, phase_d;
	logic [LEN_W-1:0] length_q, length_d;
	logic [CNT_W-1:0] bytes_seen_q, bytes_seen_d;
	logic [CRC_W-1:0] crc_q, crc_d;
	logic [RX_W-1:0]  crc_lo_q, crc_lo_d;

	// result register
	logic             out_valid_q;
	ev_t              ev_q, ev_d;
	logic [RX_W-1:0]  pbyte_q, pbyte_d;
	logic [IDX_W-1:0] pidx_q, pidx_d;
	logic [LEN_W-1:0] flen_q, flen_d;
	logic [CRC_W-1:0] crcv_q, crcv_d;

	// helpers
	logic             rx_acc;
	logic [CRC_W-1:0] crc_upd;
	logic [LEN_W-1:0] len_full;
	logic [CNT_W-1:0] cnt_inc;
	logic [CRC_W-1:0] rx_crc;

	// intake stalls only while a result is held and not taken
	assign rx_ch.ready = !out_valid_q || ev_ch.ready;
	assign rx_acc      = rx_ch.valid && rx_ch.ready;

	assign cfg_ch.ready = 1'b1;

	assign crc_upd  = crc_arc_byte(crc_q, rx_ch.rx_byte);
	// length assembled from the low byte already held and the incoming high byte
	assign len_full = {rx_ch.rx_byte, length_q[RX_W-1:0]};
	assign cnt_inc  = bytes_seen_q + 1'b1;
	assign rx_crc   = {rx_ch.rx_byte, crc_lo_q};

	// next state and result of the current byte
	always_comb begin
		phase_d      = phase_q;
		length_d     = length_q;
		bytes_seen_d = bytes_seen_q;
		crc_d        = crc_q;
		crc_lo_d     = crc_lo_q;
		ev_d         = EV_NONE;
		pbyte_d      = '0;
		pidx_d       = '0;
		flen_d       = '0;
		crcv_d       = '0;
		unique case (phase_q)
			PH_HEAD0: begin
				phase_d = (rx_ch.rx_byte == hdr_first_q) ? PH_HEAD1 : PH_HEAD0;
			end
			PH_HEAD1: begin
				phase_d = (rx_ch.rx_byte == hdr_second_q) ? PH_HEAD2 : PH_HEAD0;
			end
			PH_HEAD2: begin
				// full header seen: the crc restarts for the length field
				if (rx_ch.rx_byte == hdr_third_q) begin
					phase_d = PH_LENLO;
					crc_d   = CRC_INIT;
				end else begin
					phase_d = PH_HEAD0;
				end
			end
			PH_LENLO: begin
				length_d = {{(LEN_W-RX_W){1'b0}}, rx_ch.rx_byte};
				crc_d    = crc_upd;
				phase_d  = PH_LENHI;
			end
			PH_LENHI: begin
				length_d     = len_full;
				crc_d        = crc_upd;
				bytes_seen_d = '0;
				priority if (len_full > LEN_W'(MAX_PAYLOAD)) begin
					// oversize frame is dropped
					ev_d    = EV_LENERR;
					flen_d  = len_full;
					phase_d = PH_HEAD0;
				end else if (len_full == '0) begin
					// empty payload goes straight to the crc
					phase_d = PH_CRCLO;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				crc_d        = crc_upd;
				ev_d         = EV_PAYLOAD;
				pbyte_d      = rx_ch.rx_byte;
				pidx_d       = bytes_seen_q[IDX_W-1:0];
				flen_d       = length_q;
				bytes_seen_d = cnt_inc;
				if (LEN_W'(cnt_inc) >= length_q) begin
					phase_d = PH_CRCLO;
				end
			end
			PH_CRCLO: begin
				crc_lo_d = rx_ch.rx_byte;
				phase_d  = PH_CRCHI;
			end
			PH_CRCHI: begin
				ev_d    = (rx_crc == crc_q) ? EV_GOOD : EV_CRCERR;
				flen_d  = length_q;
				crcv_d  = crc_q;
				phase_d = PH_HEAD0;
			end
		endcase
	end

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD0;
		end else if (rx_acc) begin
			phase_q <= phase_d;
		end
	end

	// frame bookkeeping, every field is loaded before it is used
	always_ff @(posedge clk) begin
		if (rx_acc) begin
			length_q     <= length_d;
			bytes_seen_q <= bytes_seen_d;
			crc_q        <= crc_d;
			crc_lo_q     <= crc_lo_d;
		end
	end

	// header byte registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_first_q  <= HDR_FIRST_RST;
			hdr_second_q <= HDR_SECOND_RST;
			hdr_third_q  <= HDR_THIRD_RST;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				REG_HDR_FIRST:  hdr_first_q  <= cfg_ch.data;
				REG_HDR_SECOND: hdr_second_q <= cfg_ch.data;
				REG_HDR_THIRD:  hdr_third_q  <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rx_acc) begin
			out_valid_q <= 1'b1;
		end else if (ev_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (rx_acc) begin
			ev_q    <= ev_d;
			pbyte_q <= pbyte_d;
			pidx_q  <= pidx_d;
			flen_q  <= flen_d;
			crcv_q  <= crcv_d;
		end
	end

	assign ev_ch.valid         = out_valid_q;
	assign ev_ch.event_code    = ev_q;
	assign ev_ch.payload_byte  = pbyte_q;
	assign ev_ch.payload_index = pidx_q;
	assign ev_ch.frame_length  = flen_q;
	assign ev_ch.crc_value     = crcv_q;

	// a byte taken at the crc high phase always closes the frame with a verdict
	a_crchi_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_acc && phase_q == PH_CRCHI) |=>
		(ev_ch.valid && (ev_ch.event_code == EV_GOOD || ev_ch.event_code == EV_CRCERR)
			&& phase_q == PH_HEAD0))
		else $error("crc high byte did not close the frame");

	// inside the payload the counter stays below the length
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (LEN_W'(bytes_seen_q) < length_q))
		else $error("payload counter reached the length inside the payload");

	// intake is refused only while a result is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ch.ready |-> ev_ch.valid)
		else $error("intake stalled with the result register empty");

	// a length error always sends the parser back to the hunt
	a_lenerr_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_acc && ev_d == EV_LENERR) |=> (phase_q == PH_HEAD0))
		else $error("length error did not restart the header hunt");

endmodule

`default_nettype wire
